/* sv/lsr_pkg.sv */
// Shared types, constants and control-store program for the GF(257)
// secret reconstruction block. No dependencies.
package lsr_pkg;

  // Field modulus and element width
  localparam int unsigned FIELD_P = 257;
  localparam int unsigned ELEM_W = 9;
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned MAX_SHARES_DEFAULT = 16;
  localparam logic [COUNT_W-1:0] SHARE_COUNT_RESET = 5'd3;

  // Inverse by d^255: one opening square, then seven multiplies by d with a
  // square between each pair
  localparam int unsigned INV_MULS = 7;
  localparam int unsigned K_W = 3;

  // Configuration register indexes
  localparam logic REG_SHARE_COUNT = 1'b0;

  // Program steps
  localparam int unsigned STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;
  localparam step_t STEP_IDLE     = 4'd0;
  localparam step_t STEP_LOOP_NUM = 4'd1;
  localparam step_t STEP_LOOP_DEN = 4'd2;
  localparam step_t STEP_INV_SQ0  = 4'd3;
  localparam step_t STEP_INV_MUL  = 4'd4;
  localparam step_t STEP_INV_SQ   = 4'd5;
  localparam step_t STEP_WEIGHT   = 4'd6;
  localparam step_t STEP_PRODUCT  = 4'd7;
  localparam step_t STEP_ACCUM    = 4'd8;

  typedef logic [ELEM_W-1:0] elem_t;

  // Multiplier operand and destination selects
  typedef enum logic [1:0] {
    A_NUM,
    A_DEN,
    A_X
  } a_sel_t;

  typedef enum logic [2:0] {
    B_NEG_L,
    B_DIFF,
    B_DEN,
    B_X,
    B_NUM,
    B_V
  } b_sel_t;

  typedef enum logic [1:0] {
    D_NONE,
    D_NUM,
    D_DEN,
    D_X
  } dest_t;

  // Jump conditions
  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_L_MORE,
    C_K_DONE,
    C_NO_START
  } cond_t;

  // One control word
  typedef struct packed {
    logic   load;
    a_sel_t a_sel;
    b_sel_t b_sel;
    dest_t  dest;
    logic   skip_eq;
    logic   l_inc;
    logic   k_clr;
    logic   k_inc;
    logic   accum;
    cond_t  cond;
    step_t  target;
  } ctl_t;

  // Status flags from the datapath to the sequencer
  typedef struct packed {
    logic start;
    logic l_more;
    logic k_done;
  } flags_t;

  // Control store
  function automatic ctl_t lsr_rom(input step_t step);
    ctl_t w;
    w = '{load: 1'b0, a_sel: A_X, b_sel: B_X, dest: D_NONE, skip_eq: 1'b0,
          l_inc: 1'b0, k_clr: 1'b0, k_inc: 1'b0, accum: 1'b0,
          cond: C_ALWAYS, target: STEP_IDLE};
    unique case (step)
      STEP_IDLE: begin
        w.load   = 1'b1;
        w.cond   = C_NO_START;
        w.target = STEP_IDLE;
      end
      STEP_LOOP_NUM: begin
        w.a_sel   = A_NUM;
        w.b_sel   = B_NEG_L;
        w.dest    = D_NUM;
        w.skip_eq = 1'b1;
        w.cond    = C_NEVER;
      end
      STEP_LOOP_DEN: begin
        w.a_sel   = A_DEN;
        w.b_sel   = B_DIFF;
        w.dest    = D_DEN;
        w.skip_eq = 1'b1;
        w.l_inc   = 1'b1;
        w.cond    = C_L_MORE;
        w.target  = STEP_LOOP_NUM;
      end
      STEP_INV_SQ0: begin
        w.a_sel = A_DEN;
        w.b_sel = B_DEN;
        w.dest  = D_X;
        w.k_clr = 1'b1;
        w.cond  = C_NEVER;
      end
      STEP_INV_MUL: begin
        w.a_sel  = A_X;
        w.b_sel  = B_DEN;
        w.dest   = D_X;
        w.k_inc  = 1'b1;
        w.cond   = C_K_DONE;
        w.target = STEP_WEIGHT;
      end
      STEP_INV_SQ: begin
        w.a_sel  = A_X;
        w.b_sel  = B_X;
        w.dest   = D_X;
        w.cond   = C_ALWAYS;
        w.target = STEP_INV_MUL;
      end
      STEP_WEIGHT: begin
        w.a_sel = A_X;
        w.b_sel = B_NUM;
        w.dest  = D_X;
        w.cond  = C_NEVER;
      end
      STEP_PRODUCT: begin
        w.a_sel = A_X;
        w.b_sel = B_V;
        w.dest  = D_X;
        w.cond  = C_NEVER;
      end
      STEP_ACCUM: begin
        w.accum  = 1'b1;
        w.cond   = C_ALWAYS;
        w.target = STEP_IDLE;
      end
      default: begin
        w.cond   = C_ALWAYS;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

/* sv/lsr_mulmod.sv */
// Multiplier modulo 257 for operands in 0..256.
// Depends on lsr_pkg for the element type.
module lsr_mulmod (
  input  lsr_pkg::elem_t a,
  input  lsr_pkg::elem_t b,
  output lsr_pkg::elem_t p
);

  logic [2*lsr_pkg::ELEM_W-1:0] prod;
  logic [lsr_pkg::ELEM_W:0]     hi;
  logic [lsr_pkg::ELEM_W:0]     lo;

  // Fold with 256 = -1 mod 257: result is low byte minus high part
  always_comb begin
    prod = a * b;
    hi   = prod[2*lsr_pkg::ELEM_W-1:8];
    lo   = {2'b00, prod[7:0]};
    if (lo >= hi) begin
      p = lsr_pkg::ELEM_W'(lo - hi);
    end else begin
      p = lsr_pkg::ELEM_W'(lo + 10'(lsr_pkg::FIELD_P) - hi);
    end
  end

endmodule

/* sv/lsr_sequencer.sv */
// Step counter and control-store fetch with conditional jumps.
// Depends on lsr_pkg for the program and control word.
module lsr_sequencer (
  input  logic            clk,
  input  logic            rst,
  input  lsr_pkg::flags_t flags,
  output lsr_pkg::ctl_t   ctl,
  output logic            busy
);

  lsr_pkg::step_t pc;
  lsr_pkg::step_t pc_next;
  logic           take;

  // Fetch the control word for the current step
  assign ctl  = lsr_pkg::lsr_rom(pc);
  assign busy = (pc != lsr_pkg::STEP_IDLE);

  // Evaluate the jump condition
  always_comb begin
    unique case (ctl.cond)
      lsr_pkg::C_NEVER:    take = 1'b0;
      lsr_pkg::C_ALWAYS:   take = 1'b1;
      lsr_pkg::C_L_MORE:   take = flags.l_more;
      lsr_pkg::C_K_DONE:   take = flags.k_done;
      lsr_pkg::C_NO_START: take = !flags.start;
      default:             take = 1'b1;
    endcase
    pc_next = take ? ctl.target : pc + 1'b1;
  end

  // Advance the step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= lsr_pkg::STEP_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

/* sv/lsr_datapath.sv */
// Datapath: operand registers, shared mod-257 multiplier, loop counters,
// round position and running sum. Depends on lsr_pkg and lsr_mulmod.
module lsr_datapath #(
  parameter int unsigned MAX_SHARES = lsr_pkg::MAX_SHARES_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  lsr_pkg::ctl_t                ctl,
  input  logic                         start,
  input  logic [lsr_pkg::COUNT_W-1:0]  share_count,
  input  lsr_pkg::elem_t               share_value,
  output lsr_pkg::flags_t              flags,
  output logic                         done,
  output lsr_pkg::elem_t               secret
);

  localparam int unsigned CW = lsr_pkg::COUNT_W;
  localparam int unsigned EW = lsr_pkg::ELEM_W;

  // Per-share working registers
  lsr_pkg::elem_t   num;
  lsr_pkg::elem_t   den;
  lsr_pkg::elem_t   x;
  lsr_pkg::elem_t   v;
  logic [CW-1:0]    j;
  logic [CW-1:0]    l;
  logic [CW-1:0]    n;
  logic [lsr_pkg::K_W-1:0] k;

  // Round state
  logic [CW-1:0]    position;
  lsr_pkg::elem_t   running_sum;

  logic [CW-1:0]    n_eff;
  lsr_pkg::elem_t   v_red;
  lsr_pkg::elem_t   neg_l;
  lsr_pkg::elem_t   diff;
  lsr_pkg::elem_t   op_a;
  lsr_pkg::elem_t   op_b;
  lsr_pkg::elem_t   prod;
  lsr_pkg::elem_t   sum_next;
  logic [EW:0]      sum_wide;
  logic             wr_en;
  logic             accept;

  assign accept = ctl.load && start;

  // Clamp the share count to 1..MAX_SHARES
  always_comb begin
    if (share_count == '0) begin
      n_eff = CW'(1);
    end else if (32'(share_count) > MAX_SHARES) begin
      n_eff = CW'(MAX_SHARES);
    end else begin
      n_eff = share_count;
    end
  end

  // Reduce the incoming value into the field
  assign v_red = (share_value >= EW'(lsr_pkg::FIELD_P)) ?
                 share_value - EW'(lsr_pkg::FIELD_P) : share_value;

  // Loop terms: -l and j - l, both mod 257
  assign neg_l = EW'(lsr_pkg::FIELD_P) - EW'(l);
  assign diff  = (j >= l) ? EW'(j - l) : EW'(lsr_pkg::FIELD_P) - EW'(l - j);

  // Operand selection
  always_comb begin
    case (ctl.a_sel)
      lsr_pkg::A_NUM: op_a = num;
      lsr_pkg::A_DEN: op_a = den;
      default:        op_a = x;
    endcase
    case (ctl.b_sel)
      lsr_pkg::B_NEG_L: op_b = neg_l;
      lsr_pkg::B_DIFF:  op_b = diff;
      lsr_pkg::B_DEN:   op_b = den;
      lsr_pkg::B_NUM:   op_b = num;
      lsr_pkg::B_V:     op_b = v;
      default:          op_b = x;
    endcase
  end

  lsr_mulmod u_mul (
    .a (op_a),
    .b (op_b),
    .p (prod)
  );

  // Skip the product term for l equal to j
  assign wr_en = !(ctl.skip_eq && (l == j));

  // Add into the running sum mod 257
  always_comb begin
    sum_wide = {1'b0, running_sum} + {1'b0, x};
    if (sum_wide >= (EW+1)'(lsr_pkg::FIELD_P)) begin
      sum_next = EW'(sum_wide - (EW+1)'(lsr_pkg::FIELD_P));
    end else begin
      sum_next = EW'(sum_wide);
    end
  end

  assign flags.start  = start;
  assign flags.l_more = (l != n);
  assign flags.k_done = (k == lsr_pkg::K_W'(lsr_pkg::INV_MULS - 1));

  // Working registers: load on accept, write back the product
  always_ff @(posedge clk) begin
    if (accept) begin
      v   <= v_red;
      j   <= position + 1'b1;
      n   <= n_eff;
      l   <= CW'(1);
      num <= EW'(1);
      den <= EW'(1);
    end else begin
      if (wr_en) begin
        case (ctl.dest)
          lsr_pkg::D_NUM: num <= prod;
          lsr_pkg::D_DEN: den <= prod;
          lsr_pkg::D_X:   x   <= prod;
          default: ;
        endcase
      end
      if (ctl.l_inc) begin
        l <= l + 1'b1;
      end
    end
    if (ctl.k_clr) begin
      k <= '0;
    end else if (ctl.k_inc) begin
      k <= k + 1'b1;
    end
  end

  // Round state and result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      position    <= '0;
      running_sum <= '0;
      done        <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.accum) begin
        if (j >= n) begin
          position    <= '0;
          running_sum <= '0;
          done        <= 1'b1;
        end else begin
          position    <= j;
          running_sum <= sum_next;
        end
      end
    end
  end

  // Hold the secret for the result beat
  always_ff @(posedge clk) begin
    if (ctl.accum && (j >= n)) begin
      secret <= sum_next;
    end
  end

endmodule

/* sv/lagrange_secret_reconstruction.sv */
// Top level of the GF(257) Shamir reconstruction block: configuration
// port, sequencer and datapath. Depends on lsr_pkg, lsr_sequencer, lsr_datapath.
//
// Shares are taken one per start beat, in x order 1..n, while busy is low.
// Each share then runs the control-store program, whose multiplying steps
// all share the one mod-257 multiplier: 2n steps for the Lagrange numerator
// and denominator, 14 for the inverse by raising to the power 255, and one
// each for weight and product, then one step for accumulation. On the closing
// share of a round, done pulses for one cycle with secret valid; the receiver
// cannot stall and must take it then. The user must write share_count over
// the APB port only while busy is low; the block itself does not enforce this.
module lagrange_secret_reconstruction #(
  parameter int unsigned MAX_SHARES = lsr_pkg::MAX_SHARES_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         start,
  input  lsr_pkg::elem_t               share_value,
  output logic                         busy,
  output logic                         done,
  output lsr_pkg::elem_t               secret
);

  logic [lsr_pkg::COUNT_W-1:0] share_count;
  lsr_pkg::ctl_t               ctl;
  lsr_pkg::flags_t             flags;

  assign pready = 1'b1;

  // Register write on the access beat
  always_ff @(posedge clk) begin
    if (rst) begin
      share_count <= lsr_pkg::SHARE_COUNT_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == lsr_pkg::REG_SHARE_COUNT)) begin
      share_count <= pwdata[lsr_pkg::COUNT_W-1:0];
    end
  end

  // Register read
  always_comb begin
    if (paddr[2] == lsr_pkg::REG_SHARE_COUNT) begin
      prdata = 32'(share_count);
    end else begin
      prdata = '0;
    end
  end

  lsr_sequencer u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctl   (ctl),
    .busy  (busy)
  );

  lsr_datapath #(
    .MAX_SHARES (MAX_SHARES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .start       (start),
    .share_count (share_count),
    .share_value (share_value),
    .flags       (flags),
    .done        (done),
    .secret      (secret)
  );

endmodule

/* tb/tb_top.sv */
// Testbench for lagrange_secret_reconstruction: directed table, then random share rounds
// checked against a GF(257) Lagrange interpolation predictor built into this file.
// Depends on lsr_pkg and the block's RTL.
module tb_top;

  localparam int unsigned NSHARE_MAX = lsr_pkg::MAX_SHARES_DEFAULT;
  localparam int unsigned RANDOM_ITEMS = 1400;
  localparam int unsigned SETTLE_CYCLES = 60;

  // One row of the directed table: a register write or a share beat
  typedef struct packed {
    logic           is_cfg;
    logic [8:0]     data;
    logic           typed;
    lsr_pkg::elem_t want;
  } stim_row_t;

  localparam int N_DIR = 22;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           psel = 1'b0;
  logic           penable = 1'b0;
  logic           pwrite = 1'b0;
  logic [2:0]     paddr = '0;
  logic [31:0]    pwdata = '0;
  logic [31:0]    prdata;
  logic           pready;
  logic           start = 1'b0;
  lsr_pkg::elem_t share_value = '0;
  logic           busy;
  logic           done;
  lsr_pkg::elem_t secret;

  // Predictor state and pending secrets
  logic [lsr_pkg::COUNT_W-1:0] pred_count;
  int unsigned                 pred_pos;
  int unsigned                 pred_sum;
  lsr_pkg::elem_t              secret_q[$];
  int                          errors = 0;
  int unsigned                 shares_sent = 0;

  stim_row_t dir_rows [N_DIR] = '{
    '{1'b0, 9'd9,   1'b0, 9'd0},    // reset count of three, constant shares
    '{1'b0, 9'd9,   1'b0, 9'd0},
    '{1'b0, 9'd9,   1'b1, 9'd9},
    '{1'b1, 9'd1,   1'b0, 9'd0},    // single share: secret is the share itself
    '{1'b0, 9'd0,   1'b1, 9'd0},
    '{1'b0, 9'd256, 1'b1, 9'd256},
    '{1'b0, 9'd257, 1'b1, 9'd0},    // value above the modulus wraps
    '{1'b0, 9'd511, 1'b1, 9'd254},
    '{1'b1, 9'd0,   1'b0, 9'd0},    // zero count behaves as one
    '{1'b0, 9'd5,   1'b1, 9'd5},
    '{1'b1, 9'd2,   1'b0, 9'd0},
    '{1'b0, 9'd40,  1'b0, 9'd0},
    '{1'b1, 9'd1,   1'b0, 9'd0},    // count lowered in mid round
    '{1'b0, 9'd50,  1'b0, 9'd0},
    '{1'b1, 9'd31,  1'b0, 9'd0},    // count saturates at the maximum
    '{1'b0, 9'd300, 1'b0, 9'd0},
    '{1'b0, 9'd1,   1'b0, 9'd0},
    '{1'b0, 9'd128, 1'b0, 9'd0},
    '{1'b1, 9'd3,   1'b0, 9'd0},    // position already at the new count
    '{1'b0, 9'd77,  1'b0, 9'd0},
    '{1'b1, 9'd16,  1'b0, 9'd0},
    '{1'b0, 9'd170, 1'b0, 9'd0}
  };

  lagrange_secret_reconstruction i_dut (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .start       (start),
    .share_value (share_value),
    .busy        (busy),
    .done        (done),
    .secret      (secret)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Lagrange weight at zero for the share at x = j among x = 1..n
  function automatic int unsigned share_weight(input int unsigned j, input int unsigned n);
    int unsigned num;
    int unsigned den;
    int unsigned inv;
    int unsigned base;
    int unsigned e;
    int unsigned l;
    num = 1;
    den = 1;
    for (l = 1; l <= n; l++) begin
      if (l != j) begin
        num = (num * ((lsr_pkg::FIELD_P - l) % lsr_pkg::FIELD_P)) % lsr_pkg::FIELD_P;
        den = (den * ((j + lsr_pkg::FIELD_P - l) % lsr_pkg::FIELD_P)) % lsr_pkg::FIELD_P;
      end
    end
    // Invert by raising to the power p - 2
    base = den;
    inv = 1;
    e = lsr_pkg::FIELD_P - 2;
    while (e != 0) begin
      if (e[0])
        inv = (inv * base) % lsr_pkg::FIELD_P;
      base = (base * base) % lsr_pkg::FIELD_P;
      e = e >> 1;
    end
    return (num * inv) % lsr_pkg::FIELD_P;
  endfunction

  // Fold one share into the round; return 1 with the secret on the closing share
  function automatic bit take_share(input logic [8:0] raw, output lsr_pkg::elem_t sec);
    int unsigned n;
    int unsigned v;
    int unsigned j;
    n = pred_count;
    if (n < 1)
      n = 1;
    if (n > NSHARE_MAX)
      n = NSHARE_MAX;
    v = raw % lsr_pkg::FIELD_P;
    j = pred_pos + 1;
    pred_sum = (pred_sum + (v * share_weight(j, n)) % lsr_pkg::FIELD_P) % lsr_pkg::FIELD_P;
    sec = lsr_pkg::elem_t'(pred_sum);
    if (j >= n) begin
      pred_pos = 0;
      pred_sum = 0;
      return 1'b1;
    end
    pred_pos = j;
    return 1'b0;
  endfunction

  // Hold until every pending secret has been taken
  task automatic drain_secrets();
    start <= 1'b0;
    while (secret_q.size() != 0)
      @(posedge clk);
  endtask

  // Write share_count once the block is idle, then read it back
  task automatic write_share_count(input logic [lsr_pkg::COUNT_W-1:0] value);
    drain_secrets();
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy)
      @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(4 * lsr_pkg::REG_SHARE_COUNT);
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    pred_count = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[lsr_pkg::COUNT_W-1:0] !== value) begin
      $display("%0t share_count read back: expected %0d actual %0d",
               $time, value, prdata[lsr_pkg::COUNT_W-1:0]);
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Drive one share beat, with an optional idle gap in front of it
  task automatic send_share(input logic [8:0] raw, input bit typed,
                            input lsr_pkg::elem_t want, input int unsigned gap_pct);
    lsr_pkg::elem_t sec;
    bit             closes;
    if ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 60)) @(posedge clk);
    end
    start       <= 1'b1;
    share_value <= raw;
    do @(posedge clk); while (busy);
    closes = take_share(raw, sec);
    if (closes)
      secret_q.push_back(typed ? want : sec);
    shares_sent++;
  endtask

  // Check each secret beat against the oldest expectation
  always @(posedge clk) begin
    if (!rst && done) begin
      if (secret_q.size() == 0) begin
        $display("%0t unexpected secret beat: expected none actual %0d", $time, secret);
        errors++;
      end else begin
        if (secret !== secret_q[0]) begin
          $display("%0t secret mismatch: expected %0d actual %0d",
                   $time, secret_q[0], secret);
          errors++;
        end
        void'(secret_q.pop_front());
      end
    end
  end

  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int unsigned gap_pcts [3];
    int unsigned phase;
    int unsigned items;
    int unsigned k;
    int unsigned pick;
    logic [lsr_pkg::COUNT_W-1:0] cnt;
    logic [8:0] raw;
    gap_pcts = '{0, 56, 33};
    pred_count = lsr_pkg::SHARE_COUNT_RESET;
    pred_pos = 0;
    pred_sum = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table
    for (k = 0; k < N_DIR; k++) begin
      if (dir_rows[k].is_cfg)
        write_share_count(dir_rows[k].data[lsr_pkg::COUNT_W-1:0]);
      else
        send_share(dir_rows[k].data, dir_rows[k].typed, dir_rows[k].want, 0);
    end

    // Random phases, each with its own count and idle rate
    phase = 0;
    while (shares_sent < N_DIR + RANDOM_ITEMS) begin
      pick = $urandom_range(9);
      case (pick)
        0: cnt = 5'd0;
        1: cnt = 5'd1;
        2: cnt = 5'(NSHARE_MAX);
        3: cnt = 5'(NSHARE_MAX + 1);
        4: cnt = 5'd31;
        default: cnt = 5'($urandom_range(2, 15));
      endcase
      write_share_count(cnt);
      items = $urandom_range(20, 80);
      for (k = 0; k < items; k++) begin
        if ($urandom_range(49) == 0)
          drain_secrets();
        if ($urandom_range(9) == 0)
          raw = 9'($urandom_range(257, 511));
        else
          raw = 9'($urandom_range(0, 256));
        send_share(raw, 1'b0, '0, gap_pcts[phase % 3]);
      end
      phase++;
    end

    // Wind down and report
    drain_secrets();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && secret_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      if (secret_q.size() != 0)
        $display("%0t secrets still pending: expected 0 actual %0d",
                 $time, secret_q.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
